// ===== rtl/vanm_pkg.sv =====
package vanm_pkg;

  // Width of one character code unit on the request port.
  localparam int ChWidth = 16;
  // Folded characters are kept as 7-bit ASCII; anything else is held as zero.
  localparam int CodeBits = 7;
  // Window of stored characters, newest first.
  localparam int WinDepth = 33;
  // Marker positions: the window plus the current character.
  localparam int MarkerLen = WinDepth + 1;
  localparam int MarkerCount = 13;
  localparam int QueueDepth = 2;

  localparam logic [CodeBits-1:0] UpperA = 7'h41;
  localparam logic [CodeBits-1:0] UpperZ = 7'h5a;
  localparam logic [CodeBits-1:0] CaseOffset = 7'h20;

  typedef logic [CodeBits-1:0] code_t;
  typedef logic [MarkerLen*8-1:0] marker_t;

  // Lower-case markers as ASCII bytes, right-aligned: the last character sits
  // in the low byte and unused leading bytes are zero. Zero bytes are skipped
  // by the compare, so no length table is needed.
  localparam marker_t Markers [MarkerCount] = '{
    272'h6e70636170206c6f6f706261636b2061646170746572,
    272'h6c6f6f706261636b2070736575646f2d696e74657266616365,
    272'h6d6963726f736f6674206b6d2d74657374206c6f6f706261636b2061646170746572,
    272'h6d6963726f736f6674206c6f6f706261636b2061646170746572,
    272'h736f667477617265206c6f6f706261636b,
    272'h68797065722d76207669727475616c2065746865726e65742061646170746572,
    272'h7669727475616c626f7820686f73742d6f6e6c79,
    272'h766d77617265206e6574776f726b2061646170746572,
    272'h7461702d77696e646f77732061646170746572,
    272'h7769726567756172642074756e6e656c,
    272'h77696e74756e,
    272'h7061636b65742063617074757265,
    272'h66696c7465722061646170746572
  };

  // Classified request, passed from the front end to the back end.
  typedef struct packed {
    code_t code;
    logic  char_valid;
    logic  str_end;
    logic  rec_end;
    logic  virt_facts;
    logic  phys_facts;
  } item_t;

endpackage

// ===== rtl/vanm_front.sv =====
module vanm_front
  import vanm_pkg::*;
#(
  parameter int CHAR_BITS = 16
) (
  input  logic [ChWidth-1:0] ch_i,
  input  logic               ch_valid_i,
  input  logic               string_end_i,
  input  logic               record_end_i,
  input  logic               loopback_or_tunnel_i,
  input  logic               filter_iface_i,
  input  logic               endpoint_iface_i,
  input  logic               hardware_iface_i,
  input  logic               connector_present_i,
  output item_t              item_o
);

  localparam int CharUsed = (CHAR_BITS < ChWidth) ? CHAR_BITS : ChWidth;
  localparam logic [ChWidth:0] KeepTop = (ChWidth + 1)'(1) << CharUsed;
  localparam logic [ChWidth-1:0] KeepMask = ChWidth'(KeepTop - (ChWidth + 1)'(1));

  logic [ChWidth-1:0] masked;
  logic               is_ascii;
  code_t              low_code;
  code_t              folded;

  assign masked   = ch_i & KeepMask;
  assign is_ascii = (masked[ChWidth-1:CodeBits] == '0);
  assign low_code = masked[CodeBits-1:0];

  // Fold capitals; a non-ASCII unit can never match and is held as zero.
  always_comb begin
    if (low_code >= UpperA && low_code <= UpperZ) begin
      folded = low_code + CaseOffset;
    end else begin
      folded = low_code;
    end
  end

  always_comb begin
    item_o.code       = is_ascii ? folded : '0;
    item_o.char_valid = ch_valid_i;
    item_o.str_end    = string_end_i | record_end_i;
    item_o.rec_end    = record_end_i;
    item_o.virt_facts = loopback_or_tunnel_i | filter_iface_i | endpoint_iface_i;
    item_o.phys_facts = hardware_iface_i & connector_present_i;
  end

endmodule

// ===== rtl/vanm_queue.sv =====
module vanm_queue
  import vanm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  item_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output item_t rd_data_o
);

  localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntBits = $clog2(QueueDepth + 1);
  localparam logic [CntBits-1:0] Full = CntBits'(QueueDepth);
  localparam logic [PtrBits-1:0] LastSlot = PtrBits'(QueueDepth - 1);

  item_t               slots_q [QueueDepth];
  logic [PtrBits-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]  count_q, count_d;
  logic                push;
  logic                pop;

  assign wr_ready_o = (count_q != Full);
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = slots_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + CntBits'(1);
      2'b01:   count_d = count_q - CntBits'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/vanm_back.sv =====
module vanm_back
  import vanm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  output logic  item_ready_o,
  input  item_t item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic  virtual_identity_o,
  output logic  physical_connector_o
);

  code_t                     win_q [WinDepth];
  code_t                     win_d [WinDepth];
  code_t                     pos   [MarkerLen];
  logic [MarkerCount-1:0]    marker_hit;
  logic                      hit;
  logic                      seen_q, seen_d;
  logic                      seen_now;
  logic                      virt;
  logic                      pop;
  logic                      out_valid_q, out_valid_d;
  logic                      virt_q, phys_q;

  // Compare positions: current character first, then the window, newest first.
  always_comb begin
    pos[0] = item_i.code;
    for (int j = 1; j < MarkerLen; j++) begin
      pos[j] = win_q[j-1];
    end
  end

  // One parallel compare per marker; zero marker bytes lie beyond its start.
  always_comb begin
    for (int m = 0; m < MarkerCount; m++) begin
      marker_hit[m] = 1'b1;
      for (int j = 0; j < MarkerLen; j++) begin
        if (Markers[m][j*8 +: 8] != 8'h00 && Markers[m][j*8 +: 8] != {1'b0, pos[j]}) begin
          marker_hit[m] = 1'b0;
        end
      end
    end
  end

  assign hit = |marker_hit;

  // Take a record end only when the result register can accept it.
  assign item_ready_o = !item_i.rec_end || !out_valid_q || out_ready_i;
  assign pop          = item_valid_i & item_ready_o;
  assign seen_now     = seen_q | (item_i.char_valid & hit);
  assign virt         = seen_now | item_i.virt_facts;

  always_comb begin
    win_d  = win_q;
    seen_d = seen_q;
    if (pop) begin
      seen_d = seen_now;
      if (item_i.char_valid) begin
        win_d[0] = item_i.code;
        for (int i = 1; i < WinDepth; i++) begin
          win_d[i] = win_q[i-1];
        end
      end
      if (item_i.str_end) begin
        for (int i = 0; i < WinDepth; i++) begin
          win_d[i] = '0;
        end
      end
      if (item_i.rec_end) begin
        seen_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop && item_i.rec_end) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinDepth; i++) begin
        win_q[i] <= '0;
      end
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && item_i.rec_end) begin
      virt_q <= virt;
      phys_q <= item_i.phys_facts & !virt;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign virtual_identity_o   = virt_q;
  assign physical_connector_o = phys_q;

endmodule

// ===== rtl/virtual_adapter_name_matcher_unit.sv =====
// A record end accepted into an empty queue passes through one queue stage,
// then the result register, before its result shows.
// One request per cycle while the queue is not full; the compare is
// combinational, and the two-entry queue absorbs requests while a result waits.
// Reset (rst_ni low, asynchronous): window and sticky match cleared, queue
// empty, no result pending.
module virtual_adapter_name_matcher_unit
  import vanm_pkg::*;
#(
  parameter int CHAR_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ChWidth-1:0] ch_i,
  input  logic               ch_valid_i,
  input  logic               string_end_i,
  input  logic               record_end_i,
  input  logic               loopback_or_tunnel_i,
  input  logic               filter_iface_i,
  input  logic               endpoint_iface_i,
  input  logic               hardware_iface_i,
  input  logic               connector_present_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               virtual_identity_o,
  output logic               physical_connector_o
);

  item_t front_item;
  item_t back_item;
  logic  back_valid;
  logic  back_ready;

  // Front end: mask to the live character bits, fold capitals, squash
  // non-ASCII units to zero and pre-combine the adapter facts.
  vanm_front #(
    .CHAR_BITS (CHAR_BITS)
  ) u_front (
    .ch_i                 (ch_i),
    .ch_valid_i           (ch_valid_i),
    .string_end_i         (string_end_i),
    .record_end_i         (record_end_i),
    .loopback_or_tunnel_i (loopback_or_tunnel_i),
    .filter_iface_i       (filter_iface_i),
    .endpoint_iface_i     (endpoint_iface_i),
    .hardware_iface_i     (hardware_iface_i),
    .connector_present_i  (connector_present_i),
    .item_o               (front_item)
  );

  // Short queue: hold classified requests while the back end is stalled
  // behind an untaken result.
  vanm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (in_valid_i),
    .wr_ready_o (in_ready_o),
    .wr_data_i  (front_item),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready),
    .rd_data_o  (back_item)
  );

  // Back end: match against the markers, advance the window, latch hits and
  // drop the result into the output register at each record end.
  vanm_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .item_valid_i         (back_valid),
    .item_ready_o         (back_ready),
    .item_i               (back_item),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .virtual_identity_o   (virtual_identity_o),
    .physical_connector_o (physical_connector_o)
  );

endmodule

// ===== rtl/vanm_checker.sv =====
module vanm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic record_end_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic virtual_identity_o,
  input logic physical_connector_o
);

  logic [2:0] pending_q;
  logic       rec_in;
  logic       res_out;

  assign rec_in  = in_valid_i & in_ready_o & record_end_i;
  assign res_out = out_valid_o & out_ready_i;

  // Count record ends taken in but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (rec_in && !res_out) begin
      pending_q <= pending_q + 3'd1;
    end else if (res_out && !rec_in) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  a_result_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_result_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(virtual_identity_o) && $stable(physical_connector_o))
    else $error("result changed while stalled");

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(virtual_identity_o && physical_connector_o))
    else $error("physical connector reported on a virtual adapter");

  a_no_invented : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("result without a record end");

endmodule

bind virtual_adapter_name_matcher_unit vanm_checker u_vanm_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_ready_o           (in_ready_o),
  .record_end_i         (record_end_i),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .virtual_identity_o   (virtual_identity_o),
  .physical_connector_o (physical_connector_o)
);

// ===== verif/virtual_adapter_name_matcher_unit_tb.sv =====
module virtual_adapter_name_matcher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape
  localparam int RandomRequests = 1950;
  localparam int MinRecords     = 48;
  localparam int DrainEvery     = 16;
  localparam int IdleLimit      = 5000;
  localparam int LongHoldCycles = 300;
  localparam int SettleCycles   = 10;
  localparam int ReportLimit    = 10;

  // Character handling: window depth, case folding bounds and test values
  localparam int          WinSize    = 33;
  localparam logic [15:0] CapA       = 16'h0041;
  localparam logic [15:0] CapZ       = 16'h005a;
  localparam logic [15:0] LowA       = 16'h0061;
  localparam logic [15:0] LowZ       = 16'h007a;
  localparam logic [15:0] CaseGap    = 16'h0020;
  localparam logic [15:0] Blank      = 16'h0020;
  localparam logic [15:0] HighAlias  = 16'h0100;
  localparam logic [15:0] MaxChar    = 16'hffff;
  localparam logic [15:0] NulChar    = 16'h0000;

  // Marker table, lower case ASCII, last character in the low byte
  localparam int NameMarkerCount = 13;
  localparam int LongestMarker   = 2;
  localparam int ShortMarker     = 10;
  localparam logic [271:0] NameMarkers [NameMarkerCount] = '{
    272'h6e70636170206c6f6f706261636b2061646170746572,
    272'h6c6f6f706261636b2070736575646f2d696e74657266616365,
    272'h6d6963726f736f6674206b6d2d74657374206c6f6f706261636b2061646170746572,
    272'h6d6963726f736f6674206c6f6f706261636b2061646170746572,
    272'h736f667477617265206c6f6f706261636b,
    272'h68797065722d76207669727475616c2065746865726e65742061646170746572,
    272'h7669727475616c626f7820686f73742d6f6e6c79,
    272'h766d77617265206e6574776f726b2061646170746572,
    272'h7461702d77696e646f77732061646170746572,
    272'h7769726567756172642074756e6e656c,
    272'h77696e74756e,
    272'h7061636b65742063617074757265,
    272'h66696c7465722061646170746572
  };

  typedef enum int {FLAW_NONE, FLAW_ZERO, FLAW_SPLIT, FLAW_ALTER, FLAW_TRUNC} flaw_e;
  typedef enum int {CASE_LOWER, CASE_UPPER, CASE_MIXED} case_e;

  typedef struct packed {
    logic loopback;
    logic filter;
    logic endpoint;
    logic hardware;
    logic connector;
  } facts_t;

  typedef struct {
    logic [15:0] ch;
    logic        has_ch;
    logic        str_end;
    logic        rec_end;
    facts_t      facts;
    bit          wait_idle;
  } request_t;

  typedef struct {
    logic virt;
    logic phys;
  } verdict_t;

  localparam facts_t NoFacts   = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam facts_t PortFacts = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
  localparam facts_t LoopFacts = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam facts_t FiltFacts = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam facts_t EndpFacts = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
  localparam facts_t AllFacts  = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

  // Block ports; the inputs are all known from time zero
  logic                        clk_i                = 1'b0;
  logic                        rst_ni               = 1'b0;
  logic                        in_valid_i           = 1'b0;
  logic                        in_ready_o;
  logic [vanm_pkg::ChWidth-1:0] ch_i                = '0;
  logic                        ch_valid_i           = 1'b0;
  logic                        string_end_i         = 1'b0;
  logic                        record_end_i         = 1'b0;
  logic                        loopback_or_tunnel_i = 1'b0;
  logic                        filter_iface_i       = 1'b0;
  logic                        endpoint_iface_i     = 1'b0;
  logic                        hardware_iface_i     = 1'b0;
  logic                        connector_present_i  = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i          = 1'b0;
  logic                        virtual_identity_o;
  logic                        physical_connector_o;

  // Requests waiting to be offered, and verdicts waiting to come out
  request_t pending_q [$];
  verdict_t verdict_q [$];

  // Predictor state: folded characters of the current string, newest first
  logic [15:0] name_window [WinSize] = '{default: 16'h0000};
  logic        name_hit = 1'b0;

  // Stimulus bookkeeping
  bit drain_next      = 1'b0;
  int planned_reqs    = 0;
  int planned_records = 0;

  // Run statistics
  int reqs_accepted  = 0;
  int records_pred   = 0;
  int marker_records = 0;
  int virt_records   = 0;
  int phys_records   = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int holds_done     = 0;
  int drains         = 0;

  // Sender and receiver pacing
  int burst_left  = 1;
  int gap_left    = 0;
  int hold_left   = 0;
  int ready_mode  = 0;
  int mode_left   = 0;
  int pattern_cnt = 0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  virtual_adapter_name_matcher_unit u_top (.*);

  // Number of characters in a marker: count bytes up to the first zero
  function automatic int marker_length(int m);
    int len;
    len = 0;
    while (len < WinSize + 1 && NameMarkers[m][8*len +: 8] != 8'h00) len++;
    return len;
  endfunction

  // Advance the predicted window and sticky hit for one accepted request;
  // queue a verdict when the request closes a record.
  function automatic void track_adapter_name(request_t r);
    logic [15:0] folded;
    int          m;
    int          k;
    bit          hit;
    verdict_t    v;
    if (r.has_ch) begin
      folded = (r.ch >= CapA && r.ch <= CapZ) ? r.ch + CaseGap : r.ch;
      for (m = 0; m < NameMarkerCount; m++) begin
        // current character against the last marker byte, window against the rest
        hit = (folded == {8'h00, NameMarkers[m][7:0]});
        for (k = 1; k < marker_length(m); k++)
          if (name_window[k-1] != {8'h00, NameMarkers[m][8*k +: 8]}) hit = 1'b0;
        if (hit) name_hit = 1'b1;
      end
      for (k = WinSize - 1; k > 0; k--) name_window[k] = name_window[k-1];
      name_window[0] = folded;
    end
    // any string end, record end included, wipes the window
    if (r.str_end || r.rec_end)
      for (k = 0; k < WinSize; k++) name_window[k] = 16'h0000;
    if (r.rec_end) begin
      v.virt = name_hit | r.facts.loopback | r.facts.filter | r.facts.endpoint;
      v.phys = r.facts.hardware & r.facts.connector & ~v.virt;
      verdict_q.push_back(v);
      records_pred++;
      if (name_hit) marker_records++;
      if (v.virt) virt_records++;
      if (v.phys) phys_records++;
      name_hit = 1'b0;
    end
  endfunction

  function automatic facts_t random_facts();
    facts_t f;
    f = 5'($urandom_range(0, 31));
    return f;
  endfunction

  // Queue one request; only requests that carry a character or an end count
  function automatic void push_request(logic [15:0] c, logic has_c, logic s_end,
                                       logic r_end, facts_t f);
    request_t r;
    r.ch        = c;
    r.has_ch    = has_c;
    r.str_end   = s_end;
    r.rec_end   = r_end;
    r.facts     = f;
    r.wait_idle = drain_next;
    drain_next  = 1'b0;
    pending_q.push_back(r);
    if (has_c || s_end || r_end) planned_reqs++;
    if (r_end) planned_records++;
  endfunction

  // Close the current string: either flag the last queued character or send an
  // end-only request. The tail only takes the flags if it is a bare character.
  function automatic void close_string(bit tack, logic s_end, logic r_end, facts_t f);
    request_t r;
    if (tack && pending_q.size() != 0 && pending_q[$].has_ch &&
        !pending_q[$].str_end && !pending_q[$].rec_end) begin
      r = pending_q.pop_back();
      planned_reqs--;
      // keep a pending drain mark on the request that replaces the tail
      if (r.wait_idle) drain_next = 1'b1;
      push_request(r.ch, 1'b1, s_end, r_end, f);
    end else begin
      push_request(16'($urandom), 1'b0, s_end, r_end, f);
    end
  endfunction

  function automatic logic [15:0] filler_char();
    case ($urandom_range(0, 7))
      0: return LowA + 16'($urandom_range(0, 25));
      1: return CapA + 16'($urandom_range(0, 25));
      2: return ($urandom_range(0, 1) == 1) ? CapA - 16'd1 : CapZ + 16'd1;
      3: return ($urandom_range(0, 1) == 1) ? LowA - 16'd1 : LowZ + 16'd1;
      4: return NulChar;
      5: return Blank;
      6: return {8'($urandom_range(1, 255)), 8'(CapA + 16'($urandom_range(0, 25)))};
      default: return 16'($urandom);
    endcase
  endfunction

  // Queue the characters of one marker, optionally spoilt: a zero slipped in,
  // a string end in the middle, one character changed, or the tail cut off.
  task automatic push_marker(int idx, case_e cmode, flaw_e flaw);
    int          len;
    int          p;
    int          k;
    logic [15:0] c;
    len = marker_length(idx);
    p   = $urandom_range(1, len - 1);
    for (k = 0; k < len; k++) begin
      c = {8'h00, NameMarkers[idx][8*(len-1-k) +: 8]};
      if (c >= LowA && c <= LowZ &&
          (cmode == CASE_UPPER || (cmode == CASE_MIXED && $urandom_range(0, 1) == 1)))
        c = c - CaseGap;
      if (flaw == FLAW_ZERO && k == p)
        push_request(NulChar, 1'b1, 1'b0, 1'b0, random_facts());
      if (flaw == FLAW_ALTER && k == p)
        c = ($urandom_range(0, 1) == 1) ? (c | HighAlias) : (c ^ 16'h0001);
      if (!(flaw == FLAW_TRUNC && k == len - 1))
        push_request(c, 1'b1, flaw == FLAW_SPLIT && k == p - 1, 1'b0, random_facts());
    end
  endtask

  // One random record: mostly two strings of filler and markers, with the odd
  // ignored request thrown in; the adapter facts lean towards zero so that
  // both verdict bits get exercised.
  task automatic build_record();
    int     n_str;
    int     s;
    int     seg;
    case_e  cm;
    facts_t f;
    n_str = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 2;
    for (s = 0; s < n_str; s++) begin
      cm = case_e'($urandom_range(0, 2));
      for (seg = $urandom_range(0, 3); seg > 0; seg--) begin
        if ($urandom_range(0, 2) == 0)
          push_marker($urandom_range(0, NameMarkerCount - 1), cm,
                      ($urandom_range(0, 1) == 0) ? flaw_e'($urandom_range(1, 4))
                                                  : FLAW_NONE);
        else
          repeat ($urandom_range(1, 6))
            push_request(filler_char(), 1'b1, 1'b0, 1'b0, random_facts());
        if ($urandom_range(0, 9) == 0)
          push_request(16'($urandom), 1'b0, 1'b0, 1'b0, random_facts());
      end
      f           = random_facts();
      f.loopback  = ($urandom_range(0, 5) == 0);
      f.filter    = ($urandom_range(0, 5) == 0);
      f.endpoint  = ($urandom_range(0, 5) == 0);
      close_string($urandom_range(0, 2) != 0,
                   (s == n_str - 1) ? 1'($urandom_range(0, 1)) : 1'b1,
                   s == n_str - 1, f);
    end
  endtask

  // Sender: predict each accepted request, then offer the next one when the
  // slot frees up. Bursts of random length alternate with random gaps; a
  // request marked to wait holds until every verdict has come out.
  always @(posedge clk_i) begin
    request_t got;
    request_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        got.ch        = ch_i;
        got.has_ch    = ch_valid_i;
        got.str_end   = string_end_i;
        got.rec_end   = record_end_i;
        got.facts     = {loopback_or_tunnel_i, filter_iface_i, endpoint_iface_i,
                         hardware_iface_i, connector_present_i};
        got.wait_idle = 1'b0;
        track_adapter_name(got);
        reqs_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].wait_idle && verdict_q.size() != 0)) begin
          nxt = pending_q.pop_front();
          if (nxt.wait_idle) drains++;
          ch_i                 <= nxt.ch;
          ch_valid_i           <= nxt.has_ch;
          string_end_i         <= nxt.str_end;
          record_end_i         <= nxt.rec_end;
          loopback_or_tunnel_i <= nxt.facts.loopback;
          filter_iface_i       <= nxt.facts.filter;
          endpoint_iface_i     <= nxt.facts.endpoint;
          hardware_iface_i     <= nxt.facts.hardware;
          connector_present_i  <= nxt.facts.connector;
          in_valid_i           <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted verdict against the oldest prediction, then
  // pick the next ready level. Twice in the run, hold ready low for a long
  // stretch so the block backs up and stalls its input.
  always @(posedge clk_i) begin
    verdict_t want;
    logic     nxt_ready;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("result %0d with nothing predicted: virtual %0b physical %0b",
                     results_seen, virtual_identity_o, physical_connector_o);
        end else begin
          want = verdict_q.pop_front();
          if (virtual_identity_o !== want.virt || physical_connector_o !== want.phys) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display("result %0d: virtual exp %0b got %0b, physical exp %0b got %0b",
                       results_seen, want.virt, virtual_identity_o,
                       want.phys, physical_connector_o);
          end
        end
      end
      pattern_cnt++;
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (holds_done < 2 && results_seen >= 12 + 30 * holds_done) begin
        hold_left = LongHoldCycles;
        holds_done++;
        nxt_ready = 1'b0;
      end else begin
        case (ready_mode)
          0:       nxt_ready = 1'b1;
          1:       nxt_ready = 1'($urandom_range(0, 1));
          2:       nxt_ready = ($urandom_range(0, 4) == 0);
          default: nxt_ready = pattern_cnt[2];
        endcase
      end
      out_ready_i <= nxt_ready;
    end
  end

  // Watchdog: end the run if neither side moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("no request or result moved for %0d cycles", IdleLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    // Directed: upper-case marker closed on its last character, nothing else set
    push_marker(ShortMarker, CASE_UPPER, FLAW_NONE);
    close_string(1'b1, 1'b1, 1'b1, NoFacts);
    // marker cut by a string end, so no hit; hardware with connector
    push_marker(ShortMarker, CASE_MIXED, FLAW_SPLIT);
    close_string(1'b1, 1'b1, 1'b1, PortFacts);
    // record end alone, no string end flag, every fact set
    close_string(1'b0, 1'b0, 1'b1, AllFacts);
    // zero character in the middle breaks the marker
    push_marker(ShortMarker, CASE_LOWER, FLAW_ZERO);
    close_string(1'b1, 1'b1, 1'b1, PortFacts);
    // top code unit ending a string, an ignored request, then a bare record end
    push_request(MaxChar, 1'b1, 1'b0, 1'b0, AllFacts);
    close_string(1'b1, 1'b1, 1'b0, AllFacts);
    push_request(16'($urandom), 1'b0, 1'b0, 1'b0, AllFacts);
    close_string(1'b0, 1'b0, 1'b1, LoopFacts);
    // filter and endpoint facts each on their own, with hardware present
    close_string(1'b0, 1'b1, 1'b1, FiltFacts);
    close_string(1'b0, 1'b1, 1'b1, EndpFacts);
    // longest marker, filling the whole window
    push_marker(LongestMarker, CASE_MIXED, FLAW_NONE);
    close_string(1'b1, 1'b1, 1'b1, NoFacts);

    // Random part; every so often let the block run dry before going on
    drain_next = 1'b1;
    while (planned_reqs < RandomRequests || planned_records < MinRecords) begin
      if (planned_records % DrainEvery == 0) drain_next = 1'b1;
      build_record();
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last request to go in, then for every verdict to come out
    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d requests, %0d records: %0d marker hits, %0d virtual, %0d physical",
             reqs_accepted, records_pred, marker_records, virt_records, phys_records);
    $display("receiver long holds %0d, sender drains %0d, mismatches %0d",
             holds_done, drains, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
